@@ src/zrld_pkg.sv @@
package zrld_pkg;

   localparam logic [7:0]  ESC_BYTE      = 8'hFF;
   localparam logic [8:0]  ZERO_RUN_BASE = 9'd4;
   localparam int          LIMIT_W       = 44;
   localparam int          TOTAL_W       = 45;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // escape tracking: number of FF bytes held back
   localparam logic [1:0]  PEND_NONE = 2'd0;
   localparam logic [1:0]  PEND_ONE  = 2'd1;
   localparam logic [1:0]  PEND_TWO  = 2'd2;

   // result FIFO depth and its pointer width
   localparam int          FIFO_DEPTH = 3;
   localparam int          PTR_W      = 2;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] run_value;
      logic [8:0] run_count;
      logic       last_of_item;
      logic       stream_done;
      logic       overflow;
   } rsp_type;

   // per-stream decoder state
   typedef struct packed {
      logic [1:0]         pending;
      logic [TOTAL_W-1:0] total;
      logic               ovf;
   } dec_state_type;

   // decoder result: up to two runs per item
   typedef struct packed {
      logic [1:0] num;
      rsp_type    run0;
      rsp_type    run1;
   } dec_out_type;

endpackage

@@ src/zrld_dec.sv @@
module zrld_dec (
   input  zrld_pkg::req_type                 item,
   input  zrld_pkg::dec_state_type           state_cur,
   input  logic [zrld_pkg::LIMIT_W-1:0]      size_limit,
   output zrld_pkg::dec_out_type             result,
   output zrld_pkg::dec_state_type           state_nxt
);
   import zrld_pkg::*;

   logic               is_esc;
   logic [1:0]         num;
   logic [1:0]         pend_nxt;
   logic [7:0]         val0;
   logic [8:0]         cnt0;
   logic [TOTAL_W:0]   sum1;
   logic [TOTAL_W:0]   sum2;
   logic [TOTAL_W-1:0] tot1;
   logic [TOTAL_W-1:0] tot2;
   logic               ovf1;
   logic               ovf2;

   assign is_esc = (item.byte_in == ESC_BYTE);

   // escape parsing
   always_comb begin
      num      = 2'd1;
      pend_nxt = PEND_NONE;
      val0     = item.byte_in;
      cnt0     = 9'd1;
      case (state_cur.pending)
         PEND_NONE: begin
            if (is_esc && !item.last_byte) begin
               num      = 2'd0;
               pend_nxt = PEND_ONE;
            end
         end
         PEND_ONE: begin
            if (is_esc) begin
               if (item.last_byte) begin
                  val0 = ESC_BYTE;
                  cnt0 = 9'd2;
               end else begin
                  num      = 2'd0;
                  pend_nxt = PEND_TWO;
               end
            end else begin
               // held FF is a literal, then this byte
               num  = 2'd2;
               val0 = ESC_BYTE;
            end
         end
         default: begin
            // two FF held: escape completes
            if (is_esc) begin
               val0 = ESC_BYTE;
               cnt0 = 9'd2;
            end else begin
               val0 = 8'h00;
               cnt0 = ZERO_RUN_BASE + {1'b0, item.byte_in};
            end
         end
      endcase
   end

   // running totals, saturating; second run only occurs when the first counts one
   assign sum1 = {1'b0, state_cur.total} + {{(TOTAL_W-8){1'b0}}, cnt0};
   assign sum2 = {1'b0, state_cur.total} + {{(TOTAL_W-1){1'b0}}, 2'd2};
   assign tot1 = sum1[TOTAL_W] ? TOTAL_MAX : sum1[TOTAL_W-1:0];
   assign tot2 = sum2[TOTAL_W] ? TOTAL_MAX : sum2[TOTAL_W-1:0];
   assign ovf1 = state_cur.ovf || (tot1 > {1'b0, size_limit});
   assign ovf2 = ovf1 || (tot2 > {1'b0, size_limit});

   // result runs
   always_comb begin
      result.num                = num;
      result.run0.run_value     = val0;
      result.run0.run_count     = cnt0;
      result.run0.last_of_item  = (num == 2'd1);
      result.run0.stream_done   = (num == 2'd1) && item.last_byte;
      result.run0.overflow      = ovf1;
      result.run1.run_value     = item.byte_in;
      result.run1.run_count     = 9'd1;
      result.run1.last_of_item  = 1'b1;
      result.run1.stream_done   = item.last_byte;
      result.run1.overflow      = ovf2;
   end

   // next state; end of stream clears everything
   always_comb begin
      state_nxt.pending = pend_nxt;
      state_nxt.total   = state_cur.total;
      state_nxt.ovf     = state_cur.ovf;
      case (num)
         2'd1: begin
            state_nxt.total = tot1;
            state_nxt.ovf   = ovf1;
         end
         2'd2: begin
            state_nxt.total = tot2;
            state_nxt.ovf   = ovf2;
         end
         default: ;
      endcase
      if (item.last_byte) begin
         state_nxt.pending = PEND_NONE;
         state_nxt.total   = '0;
         state_nxt.ovf     = 1'b0;
      end
   end

endmodule

@@ src/zrld_fifo.sv @@
module zrld_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [1:0]                 push_num,
   input  zrld_pkg::rsp_type          push_d0,
   input  zrld_pkg::rsp_type          push_d1,
   output logic [1:0]                 free_slots,
   output logic                       out_valid,
   input  logic                       out_stall,
   output zrld_pkg::rsp_type          out_data
);
   import zrld_pkg::*;

   rsp_type          entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic [PTR_W-1:0] wr_nxt;
   logic             pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign out_valid  = (cnt_ff != 2'd0);
   assign out_data   = entry_ff[rd_ff];
   assign free_slots = 2'(FIFO_DEPTH) - cnt_ff;
   assign pop        = out_valid && !out_stall;
   assign wr_nxt     = ptr_inc(wr_ff);

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = pop ? ptr_inc(rd_ff) : rd_ff;
      cnt_in = cnt_ff + push_num - {1'b0, pop};
      case (push_num)
         2'd1:    wr_in = wr_nxt;
         2'd2:    wr_in = ptr_inc(wr_nxt);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_num != 2'd0) begin
         entry_ff[wr_ff] <= push_d0;
      end
      if (push_num == 2'd2) begin
         entry_ff[wr_nxt] <= push_d1;
      end
   end

endmodule

@@ src/zero_run_length_decoder.sv @@
// Channel | Ports                          | Item
// input   | req_valid, req_stall, req_data | one compressed byte, last mark
// result  | rsp_valid, rsp_stall, rsp_data | one run: value, count, flags
// config  | csr_wr_en, csr_wr_data         | size_limit (44 bits)
//
// One byte per cycle while not stalled: a byte enters the input register,
// is decoded in the next cycle and its runs land in a 3-entry result FIFO.
// A two-run byte waits for two free slots; it always follows a held FF that
// makes no run, so with the output draining one byte per cycle still holds.
// Synchronous reset clears control state and sets size_limit to all ones.
// rsp_stall backs up into the FIFO and then raises req_stall.
module zero_run_length_decoder (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  zrld_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output zrld_pkg::rsp_type            rsp_data,
   input  logic                         csr_wr_en,
   input  logic [zrld_pkg::LIMIT_W-1:0] csr_wr_data
);
   import zrld_pkg::*;

   logic                in_valid_ff, in_valid_in;
   req_type             in_data_ff;
   dec_state_type       state_ff, state_in;
   logic [LIMIT_W-1:0]  limit_ff;
   dec_out_type         dec_res;
   dec_state_type       dec_nxt;
   logic [1:0]          free_slots;
   logic                process;
   logic                accept;
   logic [1:0]          push_num;

   // decode the held byte once the FIFO can take all of its runs
   assign process   = in_valid_ff && (dec_res.num <= free_slots);
   assign req_stall = in_valid_ff && !process;
   assign accept    = req_valid && !req_stall;
   assign push_num  = process ? dec_res.num : 2'd0;

   always_comb begin
      in_valid_in = in_valid_ff;
      state_in    = state_ff;
      if (process) begin
         in_valid_in = 1'b0;
         state_in    = dec_nxt;
      end
      if (accept) begin
         in_valid_in = 1'b1;
      end
   end

   // control state and size limit
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
         limit_ff    <= {LIMIT_W{1'b1}};
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
   end

   zrld_dec u_dec (
      .item       (in_data_ff),
      .state_cur  (state_ff),
      .size_limit (limit_ff),
      .result     (dec_res),
      .state_nxt  (dec_nxt)
   );

   zrld_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_num   (push_num),
      .push_d0    (dec_res.run0),
      .push_d1    (dec_res.run1),
      .free_slots (free_slots),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_data   (rsp_data)
   );

endmodule

@@ verif/tb_zero_run_length_decoder.sv @@
module tb_zero_run_length_decoder;
   import zrld_pkg::*;

   localparam int         CYCLE_LIMIT = 200_000;
   localparam int         NUM_PHASES  = 8;
   localparam int         PHASE_ITEMS = 100;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]  csr_wr_data = '0;

   // compressed bytes waiting to go out, and runs the decoder owes us
   req_type             byte_queue [$];
   rsp_type             runs_expected [$];
   int                  queued_count   = 0;
   int                  accepted_count = 0;
   int                  error_count    = 0;
   int                  cycle_count    = 0;
   logic                req_taken      = 1'b0;

   // idle and stall rates, in percent
   int                  send_idle_pct = 0;
   int                  stall_pct     = 0;
   int                  send_pct_table  [4] = '{0, 53, 0, 7};
   int                  stall_pct_table [4] = '{0, 0, 53, 7};
   logic [LIMIT_W-1:0]  limit_table [NUM_PHASES];

   // decoder state as we expect it
   logic [1:0]          dec_pending = PEND_NONE;
   logic [TOTAL_W-1:0]  dec_total   = '0;
   logic                dec_ovf     = 1'b0;
   logic [LIMIT_W-1:0]  dec_limit   = {LIMIT_W{1'b1}};

   zero_run_length_decoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one run out: bump the saturating total and the sticky overflow
   function automatic rsp_type emit_run(input logic [7:0] value, input logic [8:0] count);
      rsp_type           run;
      logic [TOTAL_W:0]  sum;
      sum = {1'b0, dec_total} + {{(TOTAL_W-8){1'b0}}, count};
      dec_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
      if (dec_total > {1'b0, dec_limit})
         dec_ovf = 1'b1;
      run = '0;
      run.run_value = value;
      run.run_count = count;
      run.overflow  = dec_ovf;
      return run;
   endfunction

   // decode one accepted item into zero, one or two expected runs
   function automatic void decode_byte(input req_type item);
      rsp_type  runs [2];
      int       n;
      logic     is_esc;
      n = 0;
      is_esc = (item.byte_in == ESC_BYTE);
      case (dec_pending)
         PEND_NONE: begin
            if (is_esc && !item.last_byte) begin
               dec_pending = PEND_ONE;
            end else begin
               runs[n] = emit_run(item.byte_in, 9'd1);
               n++;
            end
         end
         PEND_ONE: begin
            if (is_esc && item.last_byte) begin
               runs[n] = emit_run(ESC_BYTE, 9'd2);
               n++;
               dec_pending = PEND_NONE;
            end else if (is_esc) begin
               dec_pending = PEND_TWO;
            end else begin
               // held FF was a plain literal
               runs[0] = emit_run(ESC_BYTE, 9'd1);
               runs[1] = emit_run(item.byte_in, 9'd1);
               n = 2;
               dec_pending = PEND_NONE;
            end
         end
         default: begin
            if (is_esc)
               runs[n] = emit_run(ESC_BYTE, 9'd2);
            else
               runs[n] = emit_run(8'h00, ZERO_RUN_BASE + {1'b0, item.byte_in});
            n++;
            dec_pending = PEND_NONE;
         end
      endcase
      if (n > 0) begin
         runs[n-1].last_of_item = 1'b1;
         runs[n-1].stream_done  = item.last_byte;
      end
      for (int i = 0; i < n; i++)
         runs_expected.push_back(runs[i]);
      // stream end clears everything but the limit
      if (item.last_byte) begin
         dec_pending = PEND_NONE;
         dec_total   = '0;
         dec_ovf     = 1'b0;
      end
   endfunction

   function automatic void check_run(input rsp_type got);
      rsp_type want;
      if (runs_expected.size() == 0) begin
         $error("unexpected run: value %0h count %0d", got.run_value, got.run_count);
         error_count++;
         return;
      end
      want = runs_expected.pop_front();
      if (got.run_value !== want.run_value) begin
         $error("run_value: expected %0h, got %0h", want.run_value, got.run_value);
         error_count++;
      end
      if (got.run_count !== want.run_count) begin
         $error("run_count: expected %0d, got %0d", want.run_count, got.run_count);
         error_count++;
      end
      if (got.last_of_item !== want.last_of_item) begin
         $error("last_of_item: expected %0b, got %0b", want.last_of_item, got.last_of_item);
         error_count++;
      end
      if (got.stream_done !== want.stream_done) begin
         $error("stream_done: expected %0b, got %0b", want.stream_done, got.stream_done);
         error_count++;
      end
      if (got.overflow !== want.overflow) begin
         $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
         error_count++;
      end
   endfunction

   // driver: new item once the last one went in, at a random idle rate
   always @(negedge clock) begin
      if (!reset && (req_taken || !req_valid)) begin
         if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= byte_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // monitor: check runs, predict on accepted items, watch the clock
   always @(posedge clock) begin
      cycle_count++;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_run(rsp_data);
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            decode_byte(req_data);
            accepted_count++;
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic push_item(input logic [7:0] value, input logic last);
      req_type item;
      item.byte_in   = value;
      item.last_byte = last;
      byte_queue.push_back(item);
      queued_count++;
   endtask

   // one stream: mostly well-formed escapes and literals, some broken ones
   task automatic add_stream();
      logic [7:0] stream_bytes [$];
      int         pieces;
      int         kind;
      pieces = $urandom_range(1, 16);
      for (int i = 0; i < pieces; i++) begin
         kind = $urandom_range(99);
         if (kind < 40) begin
            stream_bytes.push_back(8'($urandom_range(254)));
         end else if (kind < 62) begin
            stream_bytes.push_back(ESC_BYTE);
            stream_bytes.push_back(ESC_BYTE);
            stream_bytes.push_back(8'($urandom_range(254)));
         end else if (kind < 72) begin
            stream_bytes.push_back(ESC_BYTE);
            stream_bytes.push_back(ESC_BYTE);
            stream_bytes.push_back(ESC_BYTE);
         end else if (kind < 82) begin
            stream_bytes.push_back(ESC_BYTE);
            stream_bytes.push_back(8'($urandom_range(254)));
         end else if (kind < 90) begin
            stream_bytes.push_back(8'($urandom_range(255)));
         end else if (kind < 95) begin
            stream_bytes.push_back(ESC_BYTE);
         end else begin
            stream_bytes.push_back(ESC_BYTE);
            stream_bytes.push_back(ESC_BYTE);
         end
      end
      foreach (stream_bytes[i])
         push_item(stream_bytes[i], i == stream_bytes.size() - 1);
   endtask

   task automatic wait_drained();
      while (accepted_count != queued_count || runs_expected.size() != 0)
         @(negedge clock);
   endtask

   // held FF bytes make no run, so give the pipeline time to empty first
   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      repeat (4) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      dec_limit   = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   initial begin
      int phase_start;
      limit_table = '{44'd0, 44'd300, 44'd1, 44'd2000, {LIMIT_W{1'b1}}, 44'd40,
                      44'($urandom_range(0, 1500)), 44'($urandom_range(100, 6000))};
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, every escape form, every end-of-stream case
      @(posedge clock);
      push_item(8'h00, 1'b0);  push_item(8'hFE, 1'b0);
      push_item(ESC_BYTE, 1'b0); push_item(ESC_BYTE, 1'b0); push_item(8'h00, 1'b0);
      push_item(ESC_BYTE, 1'b0); push_item(ESC_BYTE, 1'b0); push_item(8'hFE, 1'b0);
      push_item(ESC_BYTE, 1'b0); push_item(ESC_BYTE, 1'b0); push_item(ESC_BYTE, 1'b0);
      // lone FF then a literal: two runs
      push_item(ESC_BYTE, 1'b0); push_item(8'h41, 1'b0);
      // FF FF at stream end, then a lone FF as a whole stream
      push_item(ESC_BYTE, 1'b0); push_item(ESC_BYTE, 1'b1);
      push_item(ESC_BYTE, 1'b1);
      push_item(8'h12, 1'b1);
      push_item(ESC_BYTE, 1'b0); push_item(8'h80, 1'b1);
      push_item(ESC_BYTE, 1'b0); push_item(ESC_BYTE, 1'b0); push_item(8'h07, 1'b1);
      push_item(ESC_BYTE, 1'b0); push_item(ESC_BYTE, 1'b0); push_item(ESC_BYTE, 1'b1);

      // random streams across limits, idle and stall mixes
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         write_limit(limit_table[p]);
         @(posedge clock);
         send_idle_pct = send_pct_table[p % 4];
         stall_pct     = stall_pct_table[p % 4];
         phase_start   = queued_count;
         while (queued_count - phase_start < PHASE_ITEMS / 2)
            add_stream();
         // hold the sender until every run is out
         wait_drained();
         @(posedge clock);
         while (queued_count - phase_start < PHASE_ITEMS)
            add_stream();
      end

      wait_drained();
      repeat (4) @(negedge clock);
      if (runs_expected.size() != 0) begin
         $error("%0d runs never arrived", runs_expected.size());
         error_count++;
      end
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
